### rtl/bcd_calendar_to_seconds_defines.svh
// ----------------------------------------------------------------------------
// bcd calendar to seconds assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BCD_CALENDAR_TO_SECONDS_DEFINES_SVH
`define BCD_CALENDAR_TO_SECONDS_DEFINES_SVH

// same-cycle implication
`define BCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// types, constants and helper functions of the bcd calendar converter
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int NUM_STAGES  = 7;
  localparam int PROD_W      = 47;
  localparam int QUOT_W      = 7;
  localparam int DIFF_W      = 27;
  localparam int RECIP_SHIFT = 40;

  localparam logic [24:0] SECONDS_PER_YEAR = 25'd31536000;
  localparam logic [24:0] HALF_YEAR        = 25'd15768000;
  // floor(2^40 / SECONDS_PER_YEAR)
  localparam logic [15:0] YEAR_RECIP       = 16'd34865;

  typedef struct packed {
    logic [30:0] base_seconds;
    logic [7:0]  low_count_bcd;
    logic [7:0]  tenths_bcd;
    logic [7:0]  seconds_bcd;
    logic [7:0]  minutes_bcd;
    logic [7:0]  hours_bcd;
    logic [7:0]  weekday_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  month_bcd;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] time_seconds;
    logic [20:0]        time_microseconds;
    logic               not_initialized;
  } result_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic                  in_stall;
    logic                  out_valid;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [30:0]       base;
    logic [PROD_W-1:0] prod;
    logic [8:0]        days;
    logic [7:0]        hour;
    logic [7:0]        min;
    logic [7:0]        sec;
    logic [7:0]        tenths;
    logic [7:0]        lowc;
    logic              bad;
  } stage1_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return {4'd0, b[3:0]} + 8'd10 * {4'd0, b[7:4]};
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// bcs_ctrl
// valid bits and stage enables of the conversion pipeline
// ----------------------------------------------------------------------------
module bcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               result_stall,
  output bcs_pkg::pipe_ctrl_t ctrl
);

  logic [bcs_pkg::NUM_STAGES-1:0] valid;
  logic [bcs_pkg::NUM_STAGES-1:0] adv;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[bcs_pkg::NUM_STAGES-1] = !valid[bcs_pkg::NUM_STAGES-1] || !result_stall;
    for (int k = bcs_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= sample_valid;
      end
      for (int k = 1; k < bcs_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign ctrl.en        = adv;
  assign ctrl.in_stall  = !adv[0];
  assign ctrl.out_valid = valid[bcs_pkg::NUM_STAGES-1];

endmodule

### rtl/bcs_decode.sv
// ----------------------------------------------------------------------------
// bcs_decode
// first stage: bcd decode, date check, day index and reciprocal product
// ----------------------------------------------------------------------------
module bcs_decode (
  input  logic             clk,
  input  logic             en,
  input  bcs_pkg::sample_t sample,
  output bcs_pkg::stage1_t s1
);

  bcs_pkg::stage1_t s1_next;
  logic [7:0]       mon;
  logic [7:0]       day;
  logic [7:0]       wday;
  logic [7:0]       mon_idx;

  always_comb begin
    mon     = bcs_pkg::bcd_to_bin(sample.month_bcd);
    day     = bcs_pkg::bcd_to_bin(sample.day_bcd);
    wday    = bcs_pkg::bcd_to_bin(sample.weekday_bcd);
    mon_idx = mon - 8'd1;

    s1_next.base   = sample.base_seconds;
    s1_next.prod   = bcs_pkg::PROD_W'(sample.base_seconds)
                   * bcs_pkg::PROD_W'(bcs_pkg::YEAR_RECIP);
    s1_next.days   = bcs_pkg::cum_days(mon_idx[3:0]) + {1'b0, day} - 9'd1;
    s1_next.hour   = bcs_pkg::bcd_to_bin(sample.hours_bcd);
    s1_next.min    = bcs_pkg::bcd_to_bin(sample.minutes_bcd);
    s1_next.sec    = bcs_pkg::bcd_to_bin(sample.seconds_bcd);
    s1_next.tenths = bcs_pkg::bcd_to_bin(sample.tenths_bcd);
    s1_next.lowc   = bcs_pkg::bcd_to_bin(sample.low_count_bcd);
    s1_next.bad    = (mon < 8'd1) || (mon > 8'd12) || (day < 8'd1) || (day > 8'd31)
                   || (wday < 8'd1) || (wday > 8'd7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

### rtl/bcs_window.sv
// ----------------------------------------------------------------------------
// bcs_window
// stages two to seven: year modulo, time of year, window fold, final sum
// ----------------------------------------------------------------------------
module bcs_window (
  input  logic                clk,
  input  bcs_pkg::pipe_ctrl_t ctrl,
  input  bcs_pkg::stage1_t    s1,
  output bcs_pkg::result_t    result
);

  localparam int DW = bcs_pkg::DIFF_W;

  // stage 2
  logic [30:0] s2_base;
  logic [30:0] s2_qy;
  logic [13:0] s2_toy;
  logic [7:0]  s2_min;
  logic [7:0]  s2_sec;
  logic [14:0] s2_us;
  logic        s2_bad;
  // stage 3
  logic [30:0] s3_base;
  logic [25:0] s3_rem;
  logic [19:0] s3_toy;
  logic [7:0]  s3_sec;
  logic [20:0] s3_us;
  logic        s3_bad;
  // stage 4
  logic [30:0] s4_base;
  logic [24:0] s4_rem;
  logic [24:0] s4_toy;
  logic [20:0] s4_us;
  logic        s4_bad;
  // stage 5
  logic [30:0]          s5_base;
  logic signed [DW-1:0] s5_diff;
  logic [20:0]          s5_us;
  logic                 s5_bad;
  // stage 6
  logic [30:0]          s6_base;
  logic signed [DW-1:0] s6_diff;
  logic [20:0]          s6_us;
  logic                 s6_bad;

  logic [bcs_pkg::QUOT_W-1:0] quot;
  logic [31:0]                qy_next;
  logic [25:0]                rem_adj;
  logic signed [DW-1:0]       diff_next;
  logic signed [DW-1:0]       fold_next;
  logic signed [DW-1:0]       half;
  logic signed [DW-1:0]       year;

  always_comb begin
    quot      = s1.prod[bcs_pkg::PROD_W-1:bcs_pkg::RECIP_SHIFT];
    qy_next   = 32'(quot) * 32'(bcs_pkg::SECONDS_PER_YEAR);
    rem_adj   = s3_rem - 26'(bcs_pkg::SECONDS_PER_YEAR);
    diff_next = $signed({2'b00, s4_toy}) - $signed({2'b00, s4_rem});
    half      = $signed({2'b00, bcs_pkg::HALF_YEAR});
    year      = $signed({2'b00, bcs_pkg::SECONDS_PER_YEAR});
    priority if (s5_diff > half) begin
      fold_next = s5_diff - year;
    end else if (s5_diff < -half) begin
      fold_next = s5_diff + year;
    end else begin
      fold_next = s5_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      s2_base <= s1.base;
      s2_qy   <= qy_next[30:0];
      s2_toy  <= 14'(s1.days) * 14'd24 + 14'(s1.hour);
      s2_min  <= s1.min;
      s2_sec  <= s1.sec;
      s2_us   <= 15'(s1.tenths) * 15'd100 + 15'(s1.lowc);
      s2_bad  <= s1.bad;
    end
    if (ctrl.en[2]) begin
      s3_base <= s2_base;
      s3_rem  <= 26'(s2_base) - 26'(s2_qy);
      s3_toy  <= 20'(s2_toy) * 20'd60 + 20'(s2_min);
      s3_sec  <= s2_sec;
      s3_us   <= 21'(s2_us) * 21'd100;
      s3_bad  <= s2_bad;
    end
    if (ctrl.en[3]) begin
      s4_base <= s3_base;
      s4_rem  <= (s3_rem >= 26'(bcs_pkg::SECONDS_PER_YEAR)) ? rem_adj[24:0] : s3_rem[24:0];
      s4_toy  <= 25'(s3_toy) * 25'd60 + 25'(s3_sec);
      s4_us   <= s3_us;
      s4_bad  <= s3_bad;
    end
    if (ctrl.en[4]) begin
      s5_base <= s4_base;
      s5_diff <= diff_next;
      s5_us   <= s4_us;
      s5_bad  <= s4_bad;
    end
    if (ctrl.en[5]) begin
      s6_base <= s5_base;
      s6_diff <= fold_next;
      s6_us   <= s5_us;
      s6_bad  <= s5_bad;
    end
    if (ctrl.en[6]) begin
      result.time_seconds      <= s6_bad ? 32'sd0
                                : $signed(32'(s6_base) + {{(32-DW){s6_diff[DW-1]}}, s6_diff});
      result.time_microseconds <= s6_bad ? 21'd0 : s6_us;
      result.not_initialized   <= s6_bad;
    end
  end

endmodule

### rtl/bcd_calendar_to_seconds.sv
// ----------------------------------------------------------------------------
// bcd_calendar_to_seconds
// converts a bcd clock-chip sample to linear seconds and microseconds
// ----------------------------------------------------------------------------
// the sample channel carries eight bcd counter bytes and a 31-bit reference
// time; the result channel carries signed seconds, microseconds and a flag
// that marks an out-of-range month, day or weekday (then both times are zero)
// a request is taken when valid is high and stall is low on its channel
// the pipeline takes one request every cycle while sample_stall is low, in
// seven register stages: bcd decode with the reciprocal product, quotient
// times year length, remainder with time-of-year build, remainder correction,
// difference, half-year fold and the final sum in the output register
// a stall on the result channel holds the output stage and every full stage
// directly behind it, while a stage with an empty one after it still moves;
// sample_stall rises only when all seven stages are full and the result is
// stalled. reset clears the valid bits only; the block then accepts at once
// ----------------------------------------------------------------------------
module bcd_calendar_to_seconds (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  bcs_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output bcs_pkg::result_t result
);

  bcs_pkg::pipe_ctrl_t ctrl;
  bcs_pkg::stage1_t    s1;

  bcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .result_stall (result_stall),
    .ctrl         (ctrl)
  );

  bcs_decode u_decode (
    .clk    (clk),
    .en     (ctrl.en[0]),
    .sample (sample),
    .s1     (s1)
  );

  bcs_window u_window (
    .clk    (clk),
    .ctrl   (ctrl),
    .s1     (s1),
    .result (result)
  );

  assign sample_stall = ctrl.in_stall;
  assign result_valid = ctrl.out_valid;

endmodule

### rtl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// port-level checks of the bcd calendar converter, bound to the top level
// ----------------------------------------------------------------------------
`include "bcd_calendar_to_seconds_defines.svh"

module bcs_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input bcs_pkg::sample_t sample,
  input logic             result_valid,
  input logic             result_stall,
  input bcs_pkg::result_t result
);

  `BCS_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid, "stalled result dropped")
  `BCS_ASSERT_IMP(a_stall_only_full, clk, rst, sample_stall, result_valid && result_stall, "sample stall without full pipeline")
  `BCS_ASSERT_IMP(a_invalid_zero, clk, rst, result_valid && result.not_initialized, (result.time_seconds == 32'sd0) && (result.time_microseconds == 21'd0), "invalid date with nonzero time")
  `BCS_ASSERT_IMP(a_usec_range, clk, rst, result_valid, result.time_microseconds <= 21'd1666500, "microseconds out of range")

endmodule

bind bcd_calendar_to_seconds bcs_checker u_bcs_checker (.*);
